FILE: rtl/asla_pkg.sv
// ----------------------------------------------------------------------------
// ASID slot allocator package
// Shared widths, defaults and operation codes for the ASID slot allocator.
// ----------------------------------------------------------------------------
package asla_pkg;

  // Field widths
  localparam int unsigned ID_W      = 32;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned SLOT_W    = 2;

  // Parameter defaults
  localparam int unsigned SLOTS_DEF      = 4;
  localparam int unsigned STAMP_BITS_DEF = 32;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET     = 2'd0,
    FUNC_PROBE   = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_t;

endpackage

FILE: rtl/asla_lookup.sv
// ----------------------------------------------------------------------------
// ASID slot lookup
// Parallel tag compare with first-hit priority, and a compare tree that
// picks the slot with the lowest stamp (lowest index on ties).
// ----------------------------------------------------------------------------
module asla_lookup #(
  parameter int unsigned SLOTS      = asla_pkg::SLOTS_DEF,
  parameter int unsigned STAMP_BITS = asla_pkg::STAMP_BITS_DEF,
  localparam int unsigned IDXW      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [asla_pkg::ID_W-1:0] id_i,
  input  logic [asla_pkg::ID_W-1:0] tag_i   [SLOTS],
  input  logic [STAMP_BITS-1:0]     stamp_i [SLOTS],
  output logic                      hit_o,
  output logic [IDXW-1:0]           hit_idx_o,
  output logic [IDXW-1:0]           victim_idx_o
);

  localparam int unsigned LEAVES = 1 << IDXW;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  logic [STAMP_BITS-1:0] node_stamp [NODES];
  logic [IDXW-1:0]       node_idx   [NODES];

  // Compare all tags, keep the lowest matching index
  always_comb begin
    hit_o     = 1'b0;
    hit_idx_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (tag_i[i] == id_i) begin
        hit_o     = 1'b1;
        hit_idx_o = IDXW'(i);
      end
    end
  end

  // Min tree: leaves padded with all-ones stamps above the last slot;
  // take the right child only when strictly older
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_idx[LEAVES-1+i] = IDXW'(i);
      if (i < SLOTS) begin
        node_stamp[LEAVES-1+i] = stamp_i[i];
      end else begin
        node_stamp[LEAVES-1+i] = '1;
      end
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (node_stamp[2*n+2] < node_stamp[2*n+1]) begin
        node_stamp[n] = node_stamp[2*n+2];
        node_idx[n]   = node_idx[2*n+2];
      end else begin
        node_stamp[n] = node_stamp[2*n+1];
        node_idx[n]   = node_idx[2*n+1];
      end
    end
    victim_idx_o = node_idx[0];
  end

endmodule

FILE: rtl/asid_slot_lru_allocator_core.sv
// ----------------------------------------------------------------------------
// ASID slot LRU allocator core
// Fully associative table mapping address-space identifiers to slots, with
// stamp-based least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request passes through the request register and then the result register before out_strobe.
// Throughput: one request per cycle; busy is always low.
// The table state is read and updated in the single lookup stage, so each
// request sees every update of the one before it.
// Reset (rst_n low, synchronous): tags, stamps, counter and kernel id clear.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module asid_slot_lru_allocator_core #(
  parameter int unsigned SLOTS      = asla_pkg::SLOTS_DEF,
  parameter int unsigned STAMP_BITS = asla_pkg::STAMP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [asla_pkg::ID_W-1:0]   cfg_wdata,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic [asla_pkg::FUNC_W-1:0] in_func,
  input  logic [asla_pkg::ID_W-1:0]   in_space_id,
  // result
  output logic                        out_strobe,
  output logic [asla_pkg::SLOT_W-1:0] out_slot,
  output logic                        out_found,
  output logic                        out_allocated
);

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  logic [asla_pkg::ID_W-1:0]   kernel_id_r;
  logic                        req_vld_r;
  asla_pkg::func_t             req_func_r;
  logic [asla_pkg::ID_W-1:0]   req_id_r;

  logic [asla_pkg::ID_W-1:0]   tag_r     [SLOTS];
  logic [asla_pkg::ID_W-1:0]   tag_nxt   [SLOTS];
  logic [STAMP_BITS-1:0]       stamp_r   [SLOTS];
  logic [STAMP_BITS-1:0]       stamp_nxt [SLOTS];
  logic [STAMP_BITS-1:0]       cnt_r;
  logic [STAMP_BITS-1:0]       cnt_nxt;

  logic                        res_vld_r;
  logic [asla_pkg::SLOT_W-1:0] res_slot_r;
  logic [asla_pkg::SLOT_W-1:0] res_slot_nxt;
  logic                        res_found_r;
  logic                        res_found_nxt;
  logic                        res_alloc_r;
  logic                        res_alloc_nxt;

  logic                        hit;
  logic [IDXW-1:0]             hit_idx;
  logic [IDXW-1:0]             victim_idx;
  logic                        special;
  logic                        func_ok;

  assign busy = 1'b0;

  // Hold the kernel identifier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_id_r <= '0;
    end else if (cfg_we) begin
      kernel_id_r <= cfg_wdata;
    end
  end

  // Capture the request word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_func_r <= asla_pkg::func_t'(in_func);
      req_id_r   <= in_space_id;
    end
  end

  asla_lookup #(
    .SLOTS      (SLOTS),
    .STAMP_BITS (STAMP_BITS)
  ) u_lookup (
    .id_i         (req_id_r),
    .tag_i        (tag_r),
    .stamp_i      (stamp_r),
    .hit_o        (hit),
    .hit_idx_o    (hit_idx),
    .victim_idx_o (victim_idx)
  );

  assign special = (req_id_r == '0) || (req_id_r == kernel_id_r);

  // Resolve the request and build the table update
  always_comb begin
    tag_nxt       = tag_r;
    stamp_nxt     = stamp_r;
    cnt_nxt       = cnt_r;
    res_slot_nxt  = '0;
    res_found_nxt = 1'b0;
    res_alloc_nxt = 1'b0;
    case (req_func_r)
      asla_pkg::FUNC_GET,
      asla_pkg::FUNC_PROBE,
      asla_pkg::FUNC_RELEASE: func_ok = 1'b1;
      default:                func_ok = 1'b0;
    endcase
    if (req_vld_r && func_ok) begin
      if (special) begin
        res_found_nxt = 1'b1;
        if (req_func_r == asla_pkg::FUNC_RELEASE) begin
          tag_nxt[0] = '0;
        end
      end else if (hit) begin
        // refresh the hit slot, drop its tag on release
        stamp_nxt[hit_idx] = cnt_r;
        res_slot_nxt       = asla_pkg::SLOT_W'(hit_idx);
        res_found_nxt      = 1'b1;
        if (req_func_r == asla_pkg::FUNC_RELEASE) begin
          tag_nxt[hit_idx] = '0;
        end
      end else if (req_func_r == asla_pkg::FUNC_GET) begin
        // evict the oldest slot, advance the saturating counter
        if (cnt_r != STAMP_MAX) begin
          cnt_nxt = cnt_r + STAMP_BITS'(1);
        end
        tag_nxt[victim_idx]   = req_id_r;
        stamp_nxt[victim_idx] = cnt_nxt;
        res_slot_nxt          = asla_pkg::SLOT_W'(victim_idx);
        res_found_nxt         = 1'b1;
        res_alloc_nxt         = 1'b1;
      end
    end
  end

  // Table and counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_r[i]   <= '0;
        stamp_r[i] <= '0;
      end
      cnt_r <= '0;
    end else begin
      tag_r   <= tag_nxt;
      stamp_r <= stamp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    res_slot_r  <= res_slot_nxt;
    res_found_r <= res_found_nxt;
    res_alloc_r <= res_alloc_nxt;
  end

  assign out_strobe    = res_vld_r;
  assign out_slot      = res_slot_r;
  assign out_found     = res_found_r;
  assign out_allocated = res_alloc_r;

endmodule

FILE: rtl/asla_checker.sv
// ----------------------------------------------------------------------------
// ASID slot allocator port checker
// Watches the top-level ports for timing and result consistency.
// ----------------------------------------------------------------------------
module asla_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [asla_pkg::FUNC_W-1:0] in_func,
  input logic                        out_strobe,
  input logic [asla_pkg::SLOT_W-1:0] out_slot,
  input logic                        out_found,
  input logic                        out_allocated
);

  // Every accepted word yields a result through the request and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("accepted word produced no result");

  // No result without an accepted word ahead of it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result strobe without a request");

  // Allocation only on a get, and always found
  a_alloc_get: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_allocated) |->
      (out_found && $past(in_func, 2) == asla_pkg::FUNC_GET))
    else $error("allocation on a non-get request");

  // A miss answers slot 0
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_slot == '0))
    else $error("miss reported a nonzero slot");

endmodule

bind asid_slot_lru_allocator_core asla_checker u_asla_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_func       (in_func),
  .out_strobe    (out_strobe),
  .out_slot      (out_slot),
  .out_found     (out_found),
  .out_allocated (out_allocated)
);
